// ===== rtl/pvd_pkg.sv =====
`timescale 1ns / 1ps
// pvd_pkg: word types and lead/escape byte boundaries for the prefix varint decoder
// no dependencies

package pvd_pkg;

	// encoded stream word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       zigzag_mode;
	} pvd_in_word_t;

	// decoded number word
	typedef struct packed {
		logic signed [63:0] value;
		logic [3:0]         bytes_used;
		logic               reserved_escape;
	} pvd_out_word_t;

	// lead byte boundaries
	localparam logic [7:0] LEAD_NEG   = 8'h80;
	localparam logic [7:0] LEAD_ONE   = 8'hC0;
	localparam logic [7:0] LEAD_TWO   = 8'hE0;
	localparam logic [7:0] LEAD_THREE = 8'hF0;
	localparam logic [7:0] LEAD_FOUR  = 8'hF8;
	localparam logic [7:0] LEAD_FIVE  = 8'hFC;
	localparam logic [7:0] LEAD_SIX   = 8'hFE;
	localparam logic [7:0] LEAD_ESC   = 8'hFF;

	// escape byte boundaries
	localparam logic [7:0] ESC_SIX      = 8'h80;
	localparam logic [7:0] ESC_SEVEN    = 8'hC0;
	localparam logic [7:0] ESC_RESERVED = 8'hE0;

endpackage

// ===== rtl/pvd_chan_if.sv =====
`timescale 1ns / 1ps
// pvd_chan_if: valid/ready channel carrying one word of a given payload type
// no dependencies; payload types come from pvd_pkg at the point of use

interface pvd_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/prefix_varint_decoder.sv =====
`timescale 1ns / 1ps
// prefix_varint_decoder: byte-serial decoder of length-prefixed integers, optional zigzag
// depends on pvd_pkg and pvd_chan_if
// a number's result word is registered, valid the cycle after its last byte is accepted
// throughput: one stream byte per cycle, set by the single accumulator update per byte
// the result register parts the sides: a held result stalls the stream only while
// the receiver is not ready, and a byte is taken in the cycle that result leaves
// reset: arst_n clears decoder state and the result valid; a partial number is dropped

module prefix_varint_decoder
	import pvd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	pvd_chan_if.sink    stream,
	pvd_chan_if.source  result
);

	// decoder state
	logic [63:0] acc_q;
	logic [3:0]  remaining_q;   // payload bytes to come, zero means lead or escape byte next
	logic [3:0]  taken_q;       // bytes of the current number so far
	logic        esc_q;         // next byte is the escape byte
	logic        mode_q;        // zigzag mode latched at the lead byte

	// result register
	logic          out_valid_q;
	pvd_out_word_t out_word_q;

	// next-state and result of the byte now on the stream
	logic [63:0] acc_d;
	logic [3:0]  remaining_d;
	logic [3:0]  taken_d;
	logic        esc_d;
	logic        mode_d;
	logic        emit;
	logic        reserved;
	logic [63:0] raw;
	logic [63:0] mapped;
	logic [7:0]  b;
	logic        accept;

	assign b = stream.payload.data_byte;

	// a held result blocks the stream only until it is taken
	assign stream.ready = !out_valid_q || result.ready;
	assign accept       = stream.valid && stream.ready;

	always_comb begin
		acc_d       = acc_q;
		remaining_d = remaining_q;
		taken_d     = taken_q;
		esc_d       = esc_q;
		mode_d      = mode_q;
		emit        = 1'b0;
		reserved    = 1'b0;
		raw         = '0;

		if (esc_q) begin
			// escape byte selects the long forms or the reserved escape
			esc_d   = 1'b0;
			taken_d = 4'd2;
			if (b < ESC_SIX) begin
				acc_d       = {57'd0, b[6:0]};
				remaining_d = 4'd6;
			end else if (b < ESC_SEVEN) begin
				acc_d       = {58'd0, b[5:0]};
				remaining_d = 4'd7;
			end else if (b < ESC_RESERVED) begin
				acc_d       = '0;
				remaining_d = 4'd8;
			end else begin
				// reserved escape: all ones, flagged
				emit     = 1'b1;
				reserved = 1'b1;
				raw      = '1;
			end
		end else if (remaining_q != 4'd0) begin
			// payload byte shifts in big-endian
			acc_d       = {acc_q[55:0], b};
			taken_d     = taken_q + 4'd1;
			remaining_d = remaining_q - 4'd1;
			if (remaining_q == 4'd1) begin
				emit = 1'b1;
				raw  = {acc_q[55:0], b};
			end
		end else begin
			// lead byte
			mode_d  = stream.payload.zigzag_mode;
			taken_d = 4'd1;
			if (b < LEAD_NEG) begin
				emit = 1'b1;
				raw  = {56'd0, b};
			end else if (b < LEAD_ONE) begin
				emit = 1'b1;
				raw  = 64'd0 - {58'd0, b[5:0]};
			end else if (b < LEAD_TWO) begin
				acc_d       = {59'd0, b[4:0]};
				remaining_d = 4'd1;
			end else if (b < LEAD_THREE) begin
				acc_d       = {60'd0, b[3:0]};
				remaining_d = 4'd2;
			end else if (b < LEAD_FOUR) begin
				acc_d       = {61'd0, b[2:0]};
				remaining_d = 4'd3;
			end else if (b < LEAD_FIVE) begin
				acc_d       = {62'd0, b[1:0]};
				remaining_d = 4'd4;
			end else if (b < LEAD_SIX) begin
				acc_d       = {63'd0, b[0]};
				remaining_d = 4'd5;
			end else if (b < LEAD_ESC) begin
				acc_d       = '0;
				remaining_d = 4'd6;
			end else begin
				acc_d = '0;
				esc_d = 1'b1;
			end
		end

		// a completed number clears the decoder for the next lead byte
		if (emit) begin
			acc_d       = '0;
			remaining_d = 4'd0;
			esc_d       = 1'b0;
		end

		// zigzag: logical shift right, xor with the sign taken from bit zero
		mapped = mode_d ? ({1'b0, raw[63:1]} ^ {64{raw[0]}}) : raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			remaining_q <= '0;
			taken_q     <= '0;
			esc_q       <= 1'b0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				acc_q       <= acc_d;
				remaining_q <= remaining_d;
				taken_q     <= taken_d;
				esc_q       <= esc_d;
				mode_q      <= mode_d;
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_word_q.value           <= mapped;
			out_word_q.bytes_used      <= taken_d;
			out_word_q.reserved_escape <= reserved;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_word_q;

	// waiting for the escape byte means no payload is pending
	a_esc_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (remaining_q == 4'd0))
		else $error("escape pending with payload bytes outstanding");

	// never more than eight payload bytes outstanding
	a_remaining_range: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= 4'd8)
		else $error("payload count out of range");

	// a reserved escape always spans the lead and escape bytes
	a_reserved_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.reserved_escape) |-> (out_word_q.bytes_used == 4'd2))
		else $error("reserved escape with wrong length");

	// a number that completes is reported in the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> out_valid_q)
		else $error("completed number not reported");

endmodule

// ===== tb/tb_prefix_varint_decoder.sv =====
`timescale 1ns / 1ps
// tb_prefix_varint_decoder: self-checking bench for the prefix varint decoder, in-bench predictor
// depends on pvd_pkg, pvd_chan_if and prefix_varint_decoder

module tb_prefix_varint_decoder;
	import pvd_pkg::*;

	// longest receiver hold-off in the fill test, and the no-progress limit
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	// encoded number shapes that the stimulus can build
	typedef enum int {
		FORM_LIT, FORM_NEG, FORM_L1, FORM_L2, FORM_L3, FORM_L4, FORM_L5, FORM_L6,
		FORM_E6, FORM_E7, FORM_E8, FORM_RSV
	} num_form_e;

	logic clk;
	logic arst_n;

	pvd_chan_if #(.payload_t(pvd_in_word_t))  stream_ch ();
	pvd_chan_if #(.payload_t(pvd_out_word_t)) result_ch ();

	prefix_varint_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	// decoder state as the bench tracks it
	logic [63:0] dec_acc;
	logic [3:0]  dec_remain;
	logic [3:0]  dec_taken;
	bit          dec_esc_pending;
	bit          dec_zz_latched;

	// decoded numbers still owed by the block, oldest first
	pvd_out_word_t expected_numbers[$];

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  idle_cycles = 0;
	bit  src_idle_en = 1'b1;
	bit  sink_idle_en = 1'b1;
	bit  hold_req = 1'b0;
	bit  hold_active = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// finish a number: zigzag if latched at its lead byte, then queue the word
	task automatic close_number(input logic [63:0] raw, input bit rsv);
		pvd_out_word_t r;
		r.value           = dec_zz_latched ? ((raw >> 1) ^ {64{raw[0]}}) : raw;
		r.bytes_used      = dec_taken;
		r.reserved_escape = rsv;
		expected_numbers.push_back(r);
		dec_acc         = '0;
		dec_remain      = '0;
		dec_esc_pending = 1'b0;
	endtask

	// advance the tracked state by one accepted stream word
	task automatic decode_byte_expected(input pvd_in_word_t w);
		logic [7:0] b;
		b = w.data_byte;
		if (dec_esc_pending) begin
			// byte after 0xFF selects the long forms or the reserved escape
			dec_esc_pending = 1'b0;
			dec_taken       = 4'd2;
			if (b < ESC_SIX) begin
				dec_acc    = 64'(b[6:0]);
				dec_remain = 4'd6;
			end else if (b < ESC_SEVEN) begin
				dec_acc    = 64'(b[5:0]);
				dec_remain = 4'd7;
			end else if (b < ESC_RESERVED) begin
				dec_acc    = '0;
				dec_remain = 4'd8;
			end else begin
				close_number({64{1'b1}}, 1'b1);
			end
		end else if (dec_remain != 0) begin
			// payload bytes shift in big-endian, unsigned
			dec_acc    = {dec_acc[55:0], b};
			dec_taken  = dec_taken + 4'd1;
			dec_remain = dec_remain - 4'd1;
			if (dec_remain == 0)
				close_number(dec_acc, 1'b0);
		end else begin
			// lead byte: mode is sampled here and nowhere else
			dec_zz_latched = w.zigzag_mode;
			dec_taken      = 4'd1;
			if (b < LEAD_NEG) begin
				close_number(64'(b), 1'b0);
			end else if (b < LEAD_ONE) begin
				close_number(64'd0 - 64'(b[5:0]), 1'b0);
			end else if (b < LEAD_TWO) begin
				dec_acc    = 64'(b[4:0]);
				dec_remain = 4'd1;
			end else if (b < LEAD_THREE) begin
				dec_acc    = 64'(b[3:0]);
				dec_remain = 4'd2;
			end else if (b < LEAD_FOUR) begin
				dec_acc    = 64'(b[2:0]);
				dec_remain = 4'd3;
			end else if (b < LEAD_FIVE) begin
				dec_acc    = 64'(b[1:0]);
				dec_remain = 4'd4;
			end else if (b < LEAD_SIX) begin
				dec_acc    = 64'(b[0]);
				dec_remain = 4'd5;
			end else if (b < LEAD_ESC) begin
				dec_acc    = '0;
				dec_remain = 4'd6;
			end else begin
				dec_acc         = '0;
				dec_esc_pending = 1'b1;
			end
		end
	endtask

	// ---------------------------------------------------------------- stream side

	// offer one word, optionally after a random idle burst, and wait for the handshake
	task automatic send_byte(input logic [7:0] b, input bit zz);
		pvd_in_word_t w;
		w.data_byte   = b;
		w.zigzag_mode = zz;
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			stream_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		stream_ch.valid   <= 1'b1;
		stream_ch.payload <= w;
		@(posedge clk);
		while (!stream_ch.ready) @(posedge clk);
		decode_byte_expected(w);
		bytes_sent++;
	endtask

	// build one encoded number from the low bits of 'bits'; words after the lead carry random mode
	task automatic send_number(input num_form_e f, input logic [63:0] bits, input bit zz);
		logic [7:0] lead;
		logic [7:0] esc;
		bit         escaped;
		int         n;
		escaped = 1'b0;
		esc     = '0;
		n       = 0;
		case (f)
			FORM_LIT: lead = {1'b0, bits[6:0]};
			FORM_NEG: lead = LEAD_NEG | 8'(bits[5:0]);
			FORM_L1: begin
				lead = LEAD_ONE | (8'(bits >> 8) & 8'h1F);
				n    = 1;
			end
			FORM_L2: begin
				lead = LEAD_TWO | (8'(bits >> 16) & 8'h0F);
				n    = 2;
			end
			FORM_L3: begin
				lead = LEAD_THREE | (8'(bits >> 24) & 8'h07);
				n    = 3;
			end
			FORM_L4: begin
				lead = LEAD_FOUR | (8'(bits >> 32) & 8'h03);
				n    = 4;
			end
			FORM_L5: begin
				lead = LEAD_FIVE | (8'(bits >> 40) & 8'h01);
				n    = 5;
			end
			FORM_L6: begin
				lead = LEAD_SIX;
				n    = 6;
			end
			FORM_E6: begin
				lead    = LEAD_ESC;
				escaped = 1'b1;
				esc     = 8'(bits >> 48) & 8'h7F;
				n       = 6;
			end
			FORM_E7: begin
				lead    = LEAD_ESC;
				escaped = 1'b1;
				esc     = ESC_SIX | (8'(bits >> 56) & 8'h3F);
				n       = 7;
			end
			FORM_E8: begin
				// low escape bits carry nothing in the full form, so vary them freely
				lead    = LEAD_ESC;
				escaped = 1'b1;
				esc     = ESC_SEVEN | 8'($urandom_range(0, 31));
				n       = 8;
			end
			default: begin
				lead    = LEAD_ESC;
				escaped = 1'b1;
				esc     = ESC_RESERVED | 8'(bits[4:0]);
			end
		endcase
		send_byte(lead, zz);
		if (escaped)
			send_byte(esc, 1'($urandom_range(0, 1)));
		for (int i = n - 1; i >= 0; i--)
			send_byte(8'(bits >> (8 * i)), 1'($urandom_range(0, 1)));
	endtask

	// ---------------------------------------------------------------- result side

	// receiver: random ready bursts, idle bursts, and one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// every accepted result word is held against the oldest owed number
	always @(posedge clk) begin
		pvd_out_word_t got;
		pvd_out_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			if (expected_numbers.size() == 0) begin
				report_mismatch("unexpected word", got.value, '0);
			end else begin
				want = expected_numbers.pop_front();
				if (got.value !== want.value)
					report_mismatch("value", got.value, want.value);
				if (got.bytes_used !== want.bytes_used)
					report_mismatch("bytes_used", 64'(got.bytes_used), 64'(want.bytes_used));
				if (got.reserved_escape !== want.reserved_escape)
					report_mismatch("reserved_escape", 64'(got.reserved_escape),
						64'(want.reserved_escape));
			end
		end
	end

	// no-progress watchdog: any handshake on either channel resets the count
	always @(posedge clk) begin
		if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_prefix_varint_decoder failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// field extremes, LIT/NEG/L1/L2/L6 leads, reserved escape, zigzag on negatives, 0xFE lead
	task automatic test_directed_forms();
		send_number(FORM_LIT, 64'h0, 1'b0);
		send_number(FORM_LIT, 64'h7F, 1'b1);
		send_number(FORM_NEG, 64'h0, 1'b0);
		// most negative small value, zigzag applied to a negative raw pattern
		send_number(FORM_NEG, 64'h3F, 1'b1);
		send_number(FORM_L1, 64'h0, 1'b0);
		// mode set on the lead, random on payload words: only the lead counts
		send_number(FORM_L2, {64{1'b1}}, 1'b1);
		// 0xFE has no lead bits, value comes from the six bytes alone
		send_number(FORM_L6, {64{1'b1}}, 1'b0);
		// reserved escape, plain and with zigzag
		send_number(FORM_RSV, 64'h1F, 1'b1);
		send_number(FORM_RSV, 64'h0, 1'b0);
	endtask

	// receiver holds off long while the sender keeps offering short numbers
	task automatic test_backpressure_fill();
		stream_ch.valid <= 1'b0;
		hold_req = 1'b1;
		do @(posedge clk); while (!hold_active);
		repeat (40)
			send_number(FORM_LIT, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed numbers with random content, some raw noise bytes
	task automatic random_numbers(input int until_bytes);
		num_form_e   f;
		logic [63:0] bits;
		while (bytes_sent < until_bytes) begin
			if ($urandom_range(0, 6) == 0) begin
				send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				f = num_form_e'($urandom_range(0, 11));
				case ($urandom_range(0, 7))
					0:       bits = '0;
					1:       bits = {64{1'b1}};
					default: bits = {$urandom, $urandom};
				endcase
				send_number(f, bits, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_random_stream();
		random_numbers(400);
	endtask

	// closing stretch at full rate on both sides
	task automatic test_no_idle_tail();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		random_numbers(bytes_sent + 50);
	endtask

	initial begin
		arst_n = 1'b0;
		stream_ch.valid   <= 1'b0;
		stream_ch.payload <= '0;
		dec_acc         = '0;
		dec_remain      = '0;
		dec_taken       = '0;
		dec_esc_pending = 1'b0;
		dec_zz_latched  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_forms();
		test_backpressure_fill();
		test_random_stream();
		test_no_idle_tail();

		// drain: wait for every owed number, then let the pipeline settle
		stream_ch.valid <= 1'b0;
		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && expected_numbers.size() == 0)
			$display("tb_prefix_varint_decoder passed");
		else
			$display("tb_prefix_varint_decoder failed");
		$finish;
	end

endmodule
